@@ sv/hmp_pkg.sv @@
// Package: shared types and constants for the hash message padder.
`timescale 1ns / 1ps
`default_nettype none

package hmp_pkg;

    localparam int unsigned NUM_WORDS  = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 64;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned IDX_W      = 4;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h80;
    localparam logic [CNT_W-1:0]  LAST_BYTE   = 6'd63;
    localparam logic [2:0]        LEN_OCTET   = 3'd7;   // bytes 56..63 carry the length
    localparam logic [IDX_W-1:0]  LAST_INDEX  = 4'd15;
    localparam logic [LEN_W-1:0]  BITS_PER_BYTE = 64'd8;

    // Length byte placement
    localparam logic ORDER_MD5    = 1'b0;
    localparam logic ORDER_SHA256 = 1'b1;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Control from sequencer to the cell chain
    typedef struct packed {
        logic              shift_byte;
        logic              shift_word;
        logic [BYTE_W-1:0] byte_val;
    } chain_ctl_t;

endpackage : hmp_pkg

`default_nettype wire

@@ sv/hmp_if.sv @@
// Interfaces: message byte channel and block word channel.
`timescale 1ns / 1ps
`default_nettype none

interface hmp_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       message_end;

    modport source (output valid, has_byte, data_byte, message_end, input ready);
    modport sink   (input valid, has_byte, data_byte, message_end, output ready);
endinterface : hmp_in_if

interface hmp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_word;
    logic [3:0]  word_index;
    logic        last_word;
    logic        final_block;

    modport source (output valid, block_word, word_index, last_word, final_block,
                    input ready);
    modport sink   (input valid, block_word, word_index, last_word, final_block,
                    output ready);
endinterface : hmp_out_if

`default_nettype wire

@@ sv/hmp_cell.sv @@
// One 32-bit word cell of the block chain: byte shift and word shift.
`timescale 1ns / 1ps
`default_nettype none

module hmp_cell (
    input  wire logic                       clk,
    input  wire hmp_pkg::chain_ctl_t        ctl,
    input  wire logic [hmp_pkg::BYTE_W-1:0] byte_in,
    input  wire logic [hmp_pkg::WORD_W-1:0] word_in,
    output logic [hmp_pkg::BYTE_W-1:0]      byte_out,
    output logic [hmp_pkg::WORD_W-1:0]      word_out
);
    import hmp_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift_word)
        begin
            word_next = word_in;
        end
        else if (ctl.shift_byte)
        begin
            word_next = {byte_in, word_reg[WORD_W-1:BYTE_W]};
        end
    end

    // Payload only; every block is fully shifted in before it is read
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign byte_out = word_reg[BYTE_W-1:0];
    assign word_out = word_reg;

endmodule : hmp_cell

`default_nettype wire

@@ sv/hmp_ctrl.sv @@
// Sequencer: byte counting, padding, length insertion and word readout.
`timescale 1ns / 1ps
`default_nettype none

module hmp_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_has_byte,
    input  wire logic [hmp_pkg::BYTE_W-1:0] in_data_byte,
    input  wire logic                       in_message_end,
    input  wire logic [hmp_pkg::WORD_W-1:0] head_word,
    output hmp_pkg::chain_ctl_t             chain_ctl,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [hmp_pkg::WORD_W-1:0]      out_block_word,
    output logic [hmp_pkg::IDX_W-1:0]       out_word_index,
    output logic                            out_last_word,
    output logic                            out_final_block
);
    import hmp_pkg::*;

    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [LEN_W-1:0]   bitlen_reg, bitlen_next;
    logic               order_reg,  order_next;
    logic               pad_reg,    pad_next;     // message end seen
    logic               marker_reg, marker_next;  // 0x80 already placed
    logic               final_reg,  final_next;   // current block is the last one
    logic [IDX_W-1:0]   wcnt_reg,   wcnt_next;
    logic               ov_reg,     ov_next;

    logic [WORD_W-1:0]  oword_reg,  oword_next;
    logic [IDX_W-1:0]   oidx_reg,   oidx_next;
    logic               olast_reg,  olast_next;
    logic               ofinal_reg, ofinal_next;

    logic               in_acc;
    logic               load;
    logic [2:0]         len_sel;
    logic [LEN_W-1:0]   len_shifted;
    logic [BYTE_W-1:0]  len_byte;

    // Byte j of the length field: LSB first, or MSB first when reversed
    assign len_sel     = (order_reg == ORDER_SHA256) ? ~cnt_reg[2:0] : cnt_reg[2:0];
    assign len_shifted = bitlen_reg >> {len_sel, 3'b000};
    assign len_byte    = len_shifted[BYTE_W-1:0];

    assign in_ready = (state_reg == ST_FILL);
    assign in_acc   = in_valid && in_ready;
    assign load     = !ov_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bitlen_next = bitlen_reg;
        order_next  = cfg_we ? cfg_wdata : order_reg;
        pad_next    = pad_reg;
        marker_next = marker_reg;
        final_next  = final_reg;
        wcnt_next   = wcnt_reg;
        ov_next     = ov_reg && !out_ready;
        oword_next  = oword_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        ofinal_next = ofinal_reg;
        chain_ctl   = '0;

        case (state_reg)
            ST_FILL:
            begin
                if (in_acc)
                begin
                    if (in_has_byte)
                    begin
                        chain_ctl.shift_byte = 1'b1;
                        chain_ctl.byte_val   = in_data_byte;
                        cnt_next             = cnt_reg + 1'b1;
                        bitlen_next          = bitlen_reg + BITS_PER_BYTE;
                    end
                    if (in_message_end)
                    begin
                        pad_next = 1'b1;
                    end
                    if (in_has_byte && cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (in_message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                chain_ctl.shift_byte = 1'b1;
                cnt_next             = cnt_reg + 1'b1;
                if (!marker_reg)
                begin
                    chain_ctl.byte_val = MARKER_BYTE;
                    marker_next        = 1'b1;
                    final_next         = (cnt_reg[5:3] != LEN_OCTET);
                end
                else if (cnt_reg[5:3] == LEN_OCTET && final_reg)
                begin
                    chain_ctl.byte_val = len_byte;
                end
                if (cnt_reg == LAST_BYTE)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (load)
                begin
                    chain_ctl.shift_word = 1'b1;
                    ov_next     = 1'b1;
                    oword_next  = head_word;
                    oidx_next   = wcnt_reg;
                    olast_next  = (wcnt_reg == LAST_INDEX) && (final_reg || !pad_reg);
                    ofinal_next = final_reg;
                    wcnt_next   = wcnt_reg + 1'b1;
                    if (wcnt_reg == LAST_INDEX)
                    begin
                        if (final_reg)
                        begin
                            state_next  = ST_FILL;
                            cnt_next    = '0;
                            bitlen_next = '0;
                            pad_next    = 1'b0;
                            marker_next = 1'b0;
                            final_next  = 1'b0;
                        end
                        else if (pad_reg)
                        begin
                            state_next = ST_PAD;
                            // marker went out in this block: length block follows
                            final_next = marker_reg;
                        end
                        else
                        begin
                            state_next = ST_FILL;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FILL;
            cnt_reg    <= '0;
            bitlen_reg <= '0;
            order_reg  <= ORDER_MD5;
            pad_reg    <= 1'b0;
            marker_reg <= 1'b0;
            final_reg  <= 1'b0;
            wcnt_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bitlen_reg <= bitlen_next;
            order_reg  <= order_next;
            pad_reg    <= pad_next;
            marker_reg <= marker_next;
            final_reg  <= final_next;
            wcnt_reg   <= wcnt_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oword_reg  <= oword_next;
        oidx_reg   <= oidx_next;
        olast_reg  <= olast_next;
        ofinal_reg <= ofinal_next;
    end

    assign out_valid       = ov_reg;
    assign out_block_word  = oword_reg;
    assign out_word_index  = oidx_reg;
    assign out_last_word   = olast_reg;
    assign out_final_block = ofinal_reg;

endmodule : hmp_ctrl

`default_nettype wire

@@ sv/hash_message_padder.sv @@
// Top level: MD5 / SHA-256 message padder built on a chain of word cells.
//
// msg_in carries one beat per message byte (has_byte) and/or an end mark
// (message_end). Bytes shift into a chain of 16 word cells, eight bits per
// cycle, so after 64 bytes byte k sits little-endian in word k/4.
// A full block is read out on blk_out as 16 beats, word_index 0..15, one
// per cycle while the receiver is ready; the chain shifts one word per
// beat toward the output register and fills with zeros behind.
// At message end the sequencer keeps shifting by itself, one byte per
// cycle: the 0x80 marker, zeros, and at bytes 56..63 the 64-bit bit
// length (LSB first, or MSB first when length_byte_order is 1). A marker
// at byte 56 or later closes that block and a second, length-only block
// follows; final_block marks the words of the last block.
// Throughput: one byte per cycle while filling; msg_in is not ready during
// padding and readout. After the filling beat, the first word is valid once
// state_reg and then the output register are loaded; last_word flags the
// final beat caused by one input beat. A stalled receiver stalls readout;
// the held word stays steady. Reset clears counters, length and control.
// cfg_we writes length_byte_order; the user must write it only while idle,
// as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module hash_message_padder (
    input  wire logic clk,
    input  wire logic rst_n,
    hmp_in_if.sink    msg_in,
    hmp_out_if.source blk_out,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    import hmp_pkg::*;

    chain_ctl_t         chain_ctl;
    logic [BYTE_W-1:0]  byte_link [NUM_WORDS+1];
    logic [WORD_W-1:0]  word_link [NUM_WORDS+1];

    // Feed at the top of the chain: new bytes, zeros behind readout
    assign byte_link[NUM_WORDS] = chain_ctl.byte_val;
    assign word_link[NUM_WORDS] = '0;

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_cell
        hmp_cell u_cell (
            .clk      (clk),
            .ctl      (chain_ctl),
            .byte_in  (byte_link[i+1]),
            .word_in  (word_link[i+1]),
            .byte_out (byte_link[i]),
            .word_out (word_link[i])
        );
    end

    hmp_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (msg_in.valid),
        .in_ready        (msg_in.ready),
        .in_has_byte     (msg_in.has_byte),
        .in_data_byte    (msg_in.data_byte),
        .in_message_end  (msg_in.message_end),
        .head_word       (word_link[0]),
        .chain_ctl       (chain_ctl),
        .out_valid       (blk_out.valid),
        .out_ready       (blk_out.ready),
        .out_block_word  (blk_out.block_word),
        .out_word_index  (blk_out.word_index),
        .out_last_word   (blk_out.last_word),
        .out_final_block (blk_out.final_block)
    );

    // Low byte of the bottom cell leaves the chain unused
    logic unused_byte;
    assign unused_byte = ^byte_link[0];

endmodule : hash_message_padder

`default_nettype wire

@@ sv/hmp_checker.sv @@
// Checker on the padder's output port, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] block_word,
    input wire logic [3:0]  word_index,
    input wire logic        last_word,
    input wire logic        final_block
);

    // Held beat stays put under backpressure
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_word)
            && $stable(word_index))
        else $error("output beat changed while stalled");

    // A run only ends at the close of a block
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_word |-> word_index == 4'd15)
        else $error("last_word before word 15");

    // The final block always closes the run
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_block && word_index == 4'd15 |-> last_word)
        else $error("final block word 15 without last_word");

    // Words of a block leave back to back in order
    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && word_index != 4'd15
            |=> out_valid && word_index == $past(word_index) + 4'd1)
        else $error("gap or misorder inside a block");

endmodule : hmp_checker

bind hash_message_padder hmp_checker u_hmp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (blk_out.valid),
    .out_ready   (blk_out.ready),
    .block_word  (blk_out.block_word),
    .word_index  (blk_out.word_index),
    .last_word   (blk_out.last_word),
    .final_block (blk_out.final_block)
);

`default_nettype wire
